### rtl/ibl_pkg.sv
`timescale 1ns / 1ps
// Package for the analytic inverse bilinear block: widths, transaction types
// and the per-stage step functions of the root and divider pipelines.
// Depends on nothing; the top level imports it.
package ibl_pkg;

   localparam int CW    = 32;
   localparam int FB    = 16;
   localparam int DW    = CW + 1;
   localparam int XW    = CW + 3;
   localparam int PRW   = XW + DW;
   localparam int SW    = PRW + 1;
   localparam int BW    = SW + 1;
   localparam int MW    = BW;
   localparam int LW    = (MW + 2) / 3;
   localparam int LMW   = 3 * LW;
   localparam int RW    = 2 * MW + 2;
   localparam int ROOTW = RW / 2;
   localparam int NMW   = ROOTW + 2;
   localparam int RMW   = SW + CW;
   localparam int QBW   = CW - 1;

   typedef struct packed {
      logic signed [CW-1:0] corner0_x;
      logic signed [CW-1:0] corner0_y;
      logic signed [CW-1:0] corner1_x;
      logic signed [CW-1:0] corner1_y;
      logic signed [CW-1:0] corner2_x;
      logic signed [CW-1:0] corner2_y;
      logic signed [CW-1:0] corner3_x;
      logic signed [CW-1:0] corner3_y;
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] alpha_first;
      logic signed [CW-1:0] beta_first;
      logic signed [CW-1:0] alpha_second;
      logic signed [CW-1:0] beta_second;
      logic                 negative_discriminant;
      logic                 alpha_divisor_zero;
      logic                 beta_divisor_zero;
   } rsp_type;

   typedef struct packed {
      logic signed [BW-1:0] b;
      logic signed [BW-1:0] qmp;
      logic [SW-1:0]        dmag;
      logic                 dneg;
      logic [SW-1:0]        emag;
      logic                 eneg;
      logic                 negd;
      logic                 dz;
      logic                 ez;
   } side_type;

   typedef struct packed {
      logic negd;
      logic dz;
      logic ez;
   } flag_type;

   typedef struct packed {
      logic [RW-1:0] rad;
      logic [RW-1:0] root;
   } root_type;

   typedef struct packed {
      logic [RMW-1:0] rem;
      logic [SW-1:0]  den;
      logic [QBW-1:0] quo;
      logic           neg;
      logic           ovf;
   } lane_type;

   function automatic root_type root_step(root_type s, int k);
      root_type      o;
      logic [RW-1:0] bitv;
      logic [RW-1:0] t;
      o = s;
      bitv = RW'(1) << (2 * k);
      t = s.root + bitv;
      if (s.rad >= t) begin
         o.rad = s.rad - t;
         o.root = (s.root >> 1) + bitv;
      end else begin
         o.root = s.root >> 1;
      end
      return o;
   endfunction

   function automatic lane_type lane_init(logic signed [NMW-1:0] num, logic [SW-1:0] den,
                                          logic flip);
      lane_type       o;
      logic [NMW-1:0] mag;
      mag = num[NMW-1] ? NMW'(-num) : NMW'(num);
      o.rem = RMW'(mag) << (FB - 1);
      o.den = den;
      o.quo = '0;
      o.neg = num[NMW-1] ^ flip;
      o.ovf = 1'b0;
      return o;
   endfunction

   function automatic lane_type div_step(lane_type l, int k);
      lane_type       o;
      logic [RMW-1:0] sub;
      o = l;
      sub = RMW'(l.den) << k;
      if (l.rem >= sub) begin
         o.rem = l.rem - sub;
         o.quo[k] = 1'b1;
      end
      return o;
   endfunction

   function automatic logic signed [CW-1:0] lane_result(lane_type l);
      logic signed [CW-1:0] m;
      logic signed [CW-1:0] v;
      m = {1'b0, l.quo};
      if (l.ovf) begin
         v = l.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         v = l.neg ? -m : m;
      end
      return v;
   endfunction

endpackage

### rtl/inverse_bilinear_analytic.sv
`timescale 1ns / 1ps
// Top level of the analytic inverse bilinear block: a fully pipelined datapath.
// Depends on ibl_pkg for widths, transaction types and step functions.
//
// A transaction is taken at every clock edge where start is high; busy is
// always low, so a new query may enter in every cycle. req_data carries the
// four quad corners and the query point in signed Q16.16.
// Each result leaves on rsp_data, for one cycle, marked by rsp_valid. Results
// come out in order, one per cycle at most, at the rate the queries went in.
// The latency is set by the integer square root, which resolves one root bit
// per stage over 71 stages, and by the four dividers, which resolve one
// quotient bit per stage over 31 stages; nine stages of differences,
// products and sums come before them and four stages of set-up and
// saturation around them.
// Reset clears the valid pipeline, so nothing in flight is reported after
// it. The receiver cannot hold results off and needs none of that here.
module inverse_bilinear_analytic (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ibl_pkg::req_type req_data,
   output logic             rsp_valid,
   output ibl_pkg::rsp_type rsp_data
);
   import ibl_pkg::*;

   localparam int LAT = 9 + ROOTW + 3 + QBW + 1;
   localparam int NSD = 5 + ROOTW;
   localparam int NLN = QBW + 2;

   logic [LAT-1:0] vld_ff, vld_in;

   logic signed [DW-1:0] x2_ff, y2_ff, x3_ff, y3_ff, dx_ff, dy_ff;
   logic signed [DW-1:0] x2_in, y2_in, x3_in, y3_in, dx_in, dy_in;
   logic signed [XW-1:0] x4_ff, y4_ff, x4_in, y4_in;

   logic signed [PRW-1:0] x4dy_ff, dxy4_ff, x3y2_ff, x2y3_ff, x2dy_ff;
   logic signed [PRW-1:0] dxy2_ff, x4y3_ff, x3y4_ff, x4y2_ff, x2y4_ff;
   logic signed [PRW-1:0] x4dy_in, dxy4_in, x3y2_in, x2y3_in, x2dy_in;
   logic signed [PRW-1:0] dxy2_in, x4y3_in, x3y4_in, x4y2_in, x2y4_in;

   logic signed [SW-1:0] p_ff, q_ff, c_ff, d_ff, e_ff;
   logic signed [SW-1:0] p_in, q_in, c_in, d_in, e_in;

   logic signed [BW-1:0] b_ff, qmp_ff, b_in, qmp_in;
   logic [MW-1:0]        cmag4_ff, dmag4_ff, cmag4_in, dmag4_in;
   logic [SW-1:0]        emag_ff, emag_in;
   logic                 cdneg4_ff, dneg_ff, eneg_ff, dz_ff, ez_ff;
   logic                 cdneg4_in, dneg_in, eneg_in, dz_in, ez_in;

   logic [MW-1:0] bmag5_ff, cmag5_ff, dmag5_ff, bmag5_in;
   logic          cdneg5_ff;

   logic [LMW-1:0]    bl, cl, dl;
   logic [2*LW-1:0]   pb_ff [3][3];
   logic [2*LW-1:0]   pc_ff [3][3];
   logic [2*LW-1:0]   pb_in [3][3];
   logic [2*LW-1:0]   pc_in [3][3];
   logic              cdneg6_ff, cdneg7_ff, cdneg8_ff;

   logic [RW-1:0] rb_ff [3];
   logic [RW-1:0] rc_ff [3];
   logic [RW-1:0] rb_in [3];
   logic [RW-1:0] rc_in [3];
   logic [RW-1:0] bb_ff, cd_ff, bb_in, cd_in;

   logic signed [RW:0] disc;
   logic [RW-1:0]      cd4;

   side_type sd_ff [NSD];
   side_type sd_in [NSD];
   root_type root_ff [ROOTW+1];
   root_type root_in [ROOTW+1];

   logic signed [NMW-1:0] num_ff [4];
   logic signed [NMW-1:0] num_in [4];
   logic signed [NMW-1:0] sroot, bext, qext;
   side_type              sn_ff;

   lane_type ln_ff [NLN][4];
   lane_type ln_in [NLN][4];
   flag_type fl_ff [NLN];
   flag_type fl_in [NLN];

   rsp_type rsp_ff, rsp_in;

   assign busy = 1'b0;
   assign vld_in = {vld_ff[LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      x2_in = DW'(req_data.corner1_x) - DW'(req_data.corner0_x);
      y2_in = DW'(req_data.corner1_y) - DW'(req_data.corner0_y);
      x3_in = DW'(req_data.corner2_x) - DW'(req_data.corner0_x);
      y3_in = DW'(req_data.corner2_y) - DW'(req_data.corner0_y);
      x4_in = XW'(req_data.corner0_x) - XW'(req_data.corner1_x)
            - XW'(req_data.corner2_x) + XW'(req_data.corner3_x);
      y4_in = XW'(req_data.corner0_y) - XW'(req_data.corner1_y)
            - XW'(req_data.corner2_y) + XW'(req_data.corner3_y);
      dy_in = DW'(req_data.point_y) - DW'(req_data.corner0_y);
      dx_in = DW'(req_data.corner0_x) - DW'(req_data.point_x);
   end

   always_comb begin
      x4dy_in = PRW'(x4_ff) * PRW'(dy_ff);
      dxy4_in = PRW'(dx_ff) * PRW'(y4_ff);
      x3y2_in = PRW'(x3_ff) * PRW'(y2_ff);
      x2y3_in = PRW'(x2_ff) * PRW'(y3_ff);
      x2dy_in = PRW'(x2_ff) * PRW'(dy_ff);
      dxy2_in = PRW'(dx_ff) * PRW'(y2_ff);
      x4y3_in = PRW'(x4_ff) * PRW'(y3_ff);
      x3y4_in = PRW'(x3_ff) * PRW'(y4_ff);
      x4y2_in = PRW'(x4_ff) * PRW'(y2_ff);
      x2y4_in = PRW'(x2_ff) * PRW'(y4_ff);
   end

   always_comb begin
      p_in = SW'(x4dy_ff) + SW'(dxy4_ff);
      q_in = SW'(x3y2_ff) - SW'(x2y3_ff);
      c_in = SW'(x2dy_ff) + SW'(dxy2_ff);
      d_in = SW'(x4y3_ff) - SW'(x3y4_ff);
      e_in = SW'(x4y2_ff) - SW'(x2y4_ff);
   end

   always_comb begin
      b_in = BW'(p_ff) + BW'(q_ff);
      qmp_in = BW'(q_ff) - BW'(p_ff);
      cmag4_in = c_ff[SW-1] ? MW'(-BW'(c_ff)) : MW'(c_ff);
      dmag4_in = d_ff[SW-1] ? MW'(-BW'(d_ff)) : MW'(d_ff);
      emag_in = e_ff[SW-1] ? SW'(-e_ff) : SW'(e_ff);
      cdneg4_in = c_ff[SW-1] ^ d_ff[SW-1];
      dneg_in = d_ff[SW-1];
      eneg_in = e_ff[SW-1];
      dz_in = (d_ff == '0);
      ez_in = (e_ff == '0);
      bmag5_in = b_ff[BW-1] ? MW'(-b_ff) : MW'(b_ff);
   end

   assign bl = LMW'(bmag5_ff);
   assign cl = LMW'(cmag5_ff);
   assign dl = LMW'(dmag5_ff);

   for (genvar gi = 0; gi < 3; gi++) begin : g_row
      for (genvar gj = 0; gj < 3; gj++) begin : g_col
         assign pb_in[gi][gj] = (2*LW)'(bl[gi*LW +: LW]) * (2*LW)'(bl[gj*LW +: LW]);
         assign pc_in[gi][gj] = (2*LW)'(cl[gi*LW +: LW]) * (2*LW)'(dl[gj*LW +: LW]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rb_in[i] = RW'(pb_ff[i][0]) + (RW'(pb_ff[i][1]) << LW)
                  + (RW'(pb_ff[i][2]) << (2 * LW));
         rc_in[i] = RW'(pc_ff[i][0]) + (RW'(pc_ff[i][1]) << LW)
                  + (RW'(pc_ff[i][2]) << (2 * LW));
      end
      bb_in = rb_ff[0] + (rb_ff[1] << LW) + (rb_ff[2] << (2 * LW));
      cd_in = rc_ff[0] + (rc_ff[1] << LW) + (rc_ff[2] << (2 * LW));
   end

   always_comb begin
      cd4 = cd_ff << 2;
      disc = cdneg8_ff ? ((RW+1)'(bb_ff) - (RW+1)'(cd4)) : ((RW+1)'(bb_ff) + (RW+1)'(cd4));
      sd_in[0] = '{b: b_ff, qmp: qmp_ff, dmag: SW'(dmag4_ff), dneg: dneg_ff,
                   emag: emag_ff, eneg: eneg_ff, negd: 1'b0, dz: dz_ff, ez: ez_ff};
      for (int i = 1; i < NSD; i++) begin
         sd_in[i] = sd_ff[i-1];
      end
      sd_in[4].negd = disc[RW];
      root_in[0].rad = disc[RW] ? '0 : disc[RW-1:0];
      root_in[0].root = '0;
      for (int i = 1; i <= ROOTW; i++) begin
         root_in[i] = root_step(root_ff[i-1], ROOTW - i);
      end
   end

   always_comb begin
      sroot = $signed({2'b00, root_ff[ROOTW].root[ROOTW-1:0]});
      bext = NMW'(sd_ff[NSD-1].b);
      qext = NMW'(sd_ff[NSD-1].qmp);
      num_in[0] = sroot + bext;
      num_in[1] = qext + sroot;
      num_in[2] = sroot - bext;
      num_in[3] = sroot - qext;
   end

   always_comb begin
      ln_in[0][0] = lane_init(num_ff[0], sn_ff.dmag, sn_ff.dneg);
      ln_in[0][1] = lane_init(num_ff[1], sn_ff.emag, !sn_ff.eneg);
      ln_in[0][2] = lane_init(num_ff[2], sn_ff.dmag, !sn_ff.dneg);
      ln_in[0][3] = lane_init(num_ff[3], sn_ff.emag, sn_ff.eneg);
      fl_in[0] = '{negd: sn_ff.negd, dz: sn_ff.dz, ez: sn_ff.ez};
      for (int j = 0; j < 4; j++) begin
         ln_in[1][j] = ln_ff[0][j];
         ln_in[1][j].ovf = ln_ff[0][j].rem >= (RMW'(ln_ff[0][j].den) << (CW - 1));
      end
      fl_in[1] = fl_ff[0];
      for (int i = 2; i < NLN; i++) begin
         for (int j = 0; j < 4; j++) begin
            ln_in[i][j] = div_step(ln_ff[i-1][j], NLN - 1 - i);
         end
         fl_in[i] = fl_ff[i-1];
      end
   end

   always_comb begin
      rsp_in.alpha_first = (fl_ff[NLN-1].negd || fl_ff[NLN-1].dz) ? '0
                         : lane_result(ln_ff[NLN-1][0]);
      rsp_in.beta_first = (fl_ff[NLN-1].negd || fl_ff[NLN-1].ez) ? '0
                        : lane_result(ln_ff[NLN-1][1]);
      rsp_in.alpha_second = (fl_ff[NLN-1].negd || fl_ff[NLN-1].dz) ? '0
                          : lane_result(ln_ff[NLN-1][2]);
      rsp_in.beta_second = (fl_ff[NLN-1].negd || fl_ff[NLN-1].ez) ? '0
                         : lane_result(ln_ff[NLN-1][3]);
      rsp_in.negative_discriminant = fl_ff[NLN-1].negd;
      rsp_in.alpha_divisor_zero = fl_ff[NLN-1].dz;
      rsp_in.beta_divisor_zero = fl_ff[NLN-1].ez;
   end

   always_ff @(posedge clock) begin
      x2_ff <= x2_in;
      y2_ff <= y2_in;
      x3_ff <= x3_in;
      y3_ff <= y3_in;
      x4_ff <= x4_in;
      y4_ff <= y4_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      x4dy_ff <= x4dy_in;
      dxy4_ff <= dxy4_in;
      x3y2_ff <= x3y2_in;
      x2y3_ff <= x2y3_in;
      x2dy_ff <= x2dy_in;
      dxy2_ff <= dxy2_in;
      x4y3_ff <= x4y3_in;
      x3y4_ff <= x3y4_in;
      x4y2_ff <= x4y2_in;
      x2y4_ff <= x2y4_in;
      p_ff <= p_in;
      q_ff <= q_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      b_ff <= b_in;
      qmp_ff <= qmp_in;
      cmag4_ff <= cmag4_in;
      dmag4_ff <= dmag4_in;
      emag_ff <= emag_in;
      cdneg4_ff <= cdneg4_in;
      dneg_ff <= dneg_in;
      eneg_ff <= eneg_in;
      dz_ff <= dz_in;
      ez_ff <= ez_in;
      bmag5_ff <= bmag5_in;
      cmag5_ff <= cmag4_ff;
      dmag5_ff <= dmag4_ff;
      cdneg5_ff <= cdneg4_ff;
      pb_ff <= pb_in;
      pc_ff <= pc_in;
      cdneg6_ff <= cdneg5_ff;
      rb_ff <= rb_in;
      rc_ff <= rc_in;
      cdneg7_ff <= cdneg6_ff;
      bb_ff <= bb_in;
      cd_ff <= cd_in;
      cdneg8_ff <= cdneg7_ff;
      sd_ff <= sd_in;
      root_ff <= root_in;
      num_ff <= num_in;
      sn_ff <= sd_ff[NSD-1];
      ln_ff <= ln_in;
      fl_ff <= fl_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data = rsp_ff;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for inverse_bilinear_analytic: directed and random quad queries,
// each predicted with exact wide arithmetic and compared field by field with the result.
// Depends on ibl_pkg and the top level of the block.
module tb;
   import ibl_pkg::*;

   typedef logic signed [255:0] wide_t;

   localparam int LATENCY   = 115;
   localparam int MAX_CYCLE = 300000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type roots_pending[$];
   int      errors;
   int      cycle;
   int      sent;
   int      checked;
   int      negd_seen;
   int      dz_seen;
   int      ez_seen;
   bit      idle_on;

   inverse_bilinear_analytic u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("%0t: timeout with %0d results outstanding", $time, roots_pending.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [255:0] isqrt_wide(logic [255:0] n);
      logic [255:0] res;
      logic [255:0] bitv;
      logic [255:0] t;
      res = '0;
      for (int k = 127; k >= 0; k--) begin
         bitv = 256'(1) << (2 * k);
         t = res + bitv;
         if (n >= t) begin
            n = n - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   function automatic wide_t scaled_quotient(wide_t num, wide_t den);
      logic [255:0] nm;
      logic [255:0] dm;
      wide_t        q;
      nm = num[255] ? -num : num;
      dm = den[255] ? -den : den;
      q = wide_t'((nm << FB) / dm);
      return (num[255] != den[255]) ? -q : q;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(wide_t v);
      wide_t hi;
      wide_t lo;
      hi = (wide_t'(1) <<< (CW - 1)) - 1;
      lo = -(wide_t'(1) <<< (CW - 1));
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic rsp_type predict_roots(req_type r);
      rsp_type o;
      wide_t   x1, y1, x2, y2, x3, y3, x4, y4, dx, dy;
      wide_t   p, q, b, c, d, e, disc, s;
      x1 = wide_t'(r.corner0_x);
      y1 = wide_t'(r.corner0_y);
      x2 = wide_t'(r.corner1_x) - x1;
      y2 = wide_t'(r.corner1_y) - y1;
      x3 = wide_t'(r.corner2_x) - x1;
      y3 = wide_t'(r.corner2_y) - y1;
      x4 = x1 - wide_t'(r.corner1_x) - wide_t'(r.corner2_x) + wide_t'(r.corner3_x);
      y4 = y1 - wide_t'(r.corner1_y) - wide_t'(r.corner2_y) + wide_t'(r.corner3_y);
      dy = wide_t'(r.point_y) - y1;
      dx = x1 - wide_t'(r.point_x);
      p = x4 * dy + dx * y4;
      q = x3 * y2 - x2 * y3;
      b = p + q;
      c = x2 * dy + dx * y2;
      d = x4 * y3 - x3 * y4;
      e = x4 * y2 - x2 * y4;
      disc = b * b + 4 * c * d;
      o = '0;
      o.negative_discriminant = disc[255];
      o.alpha_divisor_zero = (d == 0);
      o.beta_divisor_zero = (e == 0);
      s = disc[255] ? wide_t'(0) : wide_t'(isqrt_wide(disc));
      if (!disc[255] && d != 0) begin
         o.alpha_first = clamp_coord(scaled_quotient(b + s, 2 * d));
         o.alpha_second = clamp_coord(scaled_quotient(s - b, -2 * d));
      end
      if (!disc[255] && e != 0) begin
         o.beta_first = clamp_coord(-scaled_quotient(q - p + s, 2 * e));
         o.beta_second = clamp_coord(scaled_quotient(p - q + s, 2 * e));
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (roots_pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = roots_pending.pop_front();
            checked++;
            if (rsp_data.alpha_first !== want.alpha_first) begin
               $display("%0t: alpha_first expected %0d actual %0d", $time,
                        want.alpha_first, rsp_data.alpha_first);
               errors++;
            end
            if (rsp_data.beta_first !== want.beta_first) begin
               $display("%0t: beta_first expected %0d actual %0d", $time,
                        want.beta_first, rsp_data.beta_first);
               errors++;
            end
            if (rsp_data.alpha_second !== want.alpha_second) begin
               $display("%0t: alpha_second expected %0d actual %0d", $time,
                        want.alpha_second, rsp_data.alpha_second);
               errors++;
            end
            if (rsp_data.beta_second !== want.beta_second) begin
               $display("%0t: beta_second expected %0d actual %0d", $time,
                        want.beta_second, rsp_data.beta_second);
               errors++;
            end
            if (rsp_data.negative_discriminant !== want.negative_discriminant) begin
               $display("%0t: negative_discriminant expected %0b actual %0b", $time,
                        want.negative_discriminant, rsp_data.negative_discriminant);
               errors++;
            end
            if (rsp_data.alpha_divisor_zero !== want.alpha_divisor_zero) begin
               $display("%0t: alpha_divisor_zero expected %0b actual %0b", $time,
                        want.alpha_divisor_zero, rsp_data.alpha_divisor_zero);
               errors++;
            end
            if (rsp_data.beta_divisor_zero !== want.beta_divisor_zero) begin
               $display("%0t: beta_divisor_zero expected %0b actual %0b", $time,
                        want.beta_divisor_zero, rsp_data.beta_divisor_zero);
               errors++;
            end
         end
      end
   end

   task automatic send_query(req_type r);
      rsp_type want;
      int      gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      want = predict_roots(r);
      negd_seen += int'(want.negative_discriminant);
      dz_seen += int'(want.alpha_divisor_zero);
      ez_seen += int'(want.beta_divisor_zero);
      roots_pending.push_back(want);
      sent++;
   endtask

   function automatic req_type make_quad(int ax, int ay, int bx, int by, int cx, int cy,
                                         int dx, int dy, int px, int py);
      req_type r;
      r.corner0_x = ax;
      r.corner0_y = ay;
      r.corner1_x = bx;
      r.corner1_y = by;
      r.corner2_x = cx;
      r.corner2_y = cy;
      r.corner3_x = dx;
      r.corner3_y = dy;
      r.point_x = px;
      r.point_y = py;
      return r;
   endfunction

   function automatic req_type random_raw();
      req_type r;
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return r;
   endfunction

   function automatic int jitter(int base, int span);
      return base + $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   // A roughly convex quad with the point near or inside it, at a random scale.
   function automatic req_type random_quad();
      int sc;
      int ox;
      int oy;
      sc = 1 << $urandom_range(4, 22);
      ox = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      oy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      return make_quad(jitter(ox, sc / 3), jitter(oy, sc / 3),
                       jitter(ox + sc, sc / 3), jitter(oy, sc / 3),
                       jitter(ox, sc / 3), jitter(oy + sc, sc / 3),
                       jitter(ox + sc, sc / 3), jitter(oy + sc, sc / 3),
                       jitter(ox + sc / 2, sc), jitter(oy + sc / 2, sc));
   endfunction

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (roots_pending.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      localparam int ONE = 1 << FB;
      localparam int MAXV = 32'h7fffffff;
      localparam int MINV = 32'h80000000;
      idle_on = 1'b0;
      send_query('0);
      send_query(make_quad(0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE / 2, ONE / 4));
      send_query(make_quad(0, 0, 2 * ONE, 0, 0, ONE, 3 * ONE, 2 * ONE, ONE, ONE / 2));
      send_query(make_quad(0, 0, ONE, 0, 0, ONE, 2 * ONE, 2 * ONE, ONE, ONE));
      send_query(make_quad(0, 0, ONE, 0, ONE, ONE, 3 * ONE, 2 * ONE, ONE, ONE));
      send_query(make_quad(0, 0, ONE, ONE, 0, ONE, 2 * ONE, 3 * ONE, ONE, ONE));
      send_query(make_quad(0, 0, ONE, 0, 0, ONE, 3 * ONE, 3 * ONE, -5 * ONE, 7 * ONE));
      send_query(make_quad(0, 0, ONE, 0, 0, ONE, 3 * ONE, 3 * ONE, 9 * ONE, -8 * ONE));
      send_query(make_quad(0, 0, 1, 0, 0, 1, 2, 3, MAXV, MINV));
      send_query(make_quad(MAXV, MAXV, MINV, MAXV, MAXV, MINV, MINV, MINV, 0, 0));
      send_query(make_quad(MINV, MINV, MAXV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV));
      send_query(make_quad(MINV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV));
      send_query(make_quad(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      send_query(make_quad(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MINV));
      send_query(make_quad(0, 0, ONE, 0, 0, ONE, ONE + 1, ONE, ONE / 3, ONE / 5));
      idle_on = 1'b1;
      repeat (6) send_query(random_raw());
   endtask

   task automatic test_random_quads(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) idle_on = 1'($urandom_range(0, 1));
         send_query(random_quad());
      end
   endtask

   task automatic test_random_raw(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 80 == 0) idle_on = 1'($urandom_range(0, 1));
         send_query(random_raw());
      end
   endtask

   initial begin
      errors = 0;
      cycle = 0;
      sent = 0;
      checked = 0;
      negd_seen = 0;
      dz_seen = 0;
      ez_seen = 0;
      idle_on = 1'b0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_quads(700);
      drain_results();
      test_random_raw(450);
      test_random_quads(500);
      drain_results();
      repeat (LATENCY + 20) @(posedge clock);
      $display("Sent %0d queries, checked %0d results.", sent, checked);
      $display("Negative discriminant %0d, alpha divisor zero %0d, beta divisor zero %0d.",
               negd_seen, dz_seen, ez_seen);
      if (errors == 0 && roots_pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
